@@ rtl/maneuver_fan_path_predictor_core_defines.svh @@
// Assertion macros shared by the predictor RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef MANEUVER_FAN_PATH_PREDICTOR_CORE_DEFINES_SVH
`define MANEUVER_FAN_PATH_PREDICTOR_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define MFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/mfp_pkg.sv @@
// Shared types, constants and tables of the maneuver fan path predictor.
// Used by every module of the block; depends on nothing.
package mfp_pkg;

	localparam int CORDIC_ITERATIONS_DEF = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam logic [15:0] FULL_TURN = 16'd46080;
	localparam logic [15:0] QUARTER_TURN = 16'd11520;
	localparam logic [15:0] HALF_SPEED = 16'd128;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [1:0] THR_ACCEL = 2'd0;
	localparam logic [1:0] THR_BRAKE = 2'd1;
	localparam logic [1:0] THR_HOLD = 2'd2;
	localparam logic [1:0] STR_LEFT = 2'd0;
	localparam logic [1:0] STR_RIGHT = 2'd1;
	localparam logic [1:0] STR_STRAIGHT = 2'd2;

	localparam logic [0:0] REG_MAX_SPEED = 1'd0;
	localparam logic [0:0] REG_MAX_TURN = 1'd1;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic [15:0] start_speed;
		logic [15:0] start_heading;
		logic signed [15:0] steps;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic [1:0] throttle;
		logic [1:0] steer;
		logic error;
		logic last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_SPEED, ST_START, ST_CORDIC, ST_MOVE, ST_EMIT
	} state_t;

	typedef struct packed {
		logic latch;
		logic load;
		logic step;
		logic cordic_start;
		logic move;
		logic next;
		logic err;
	} cmd_t;

	typedef struct packed {
		logic cordic_done;
		logic steps_done;
		logic man_last;
	} status_t;

	function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0: r = 34'sd2949120;  5'd1: r = 34'sd1740967;
			5'd2: r = 34'sd919879;   5'd3: r = 34'sd466945;
			5'd4: r = 34'sd234379;   5'd5: r = 34'sd117304;
			5'd6: r = 34'sd58666;    5'd7: r = 34'sd29335;
			5'd8: r = 34'sd14668;    5'd9: r = 34'sd7334;
			5'd10: r = 34'sd3667;    5'd11: r = 34'sd1833;
			5'd12: r = 34'sd917;     5'd13: r = 34'sd458;
			5'd14: r = 34'sd229;     5'd15: r = 34'sd115;
			5'd16: r = 34'sd57;      5'd17: r = 34'sd29;
			5'd18: r = 34'sd14;      5'd19: r = 34'sd7;
			5'd20: r = 34'sd4;       5'd21: r = 34'sd2;
			5'd22: r = 34'sd1;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
		if (v > 35'sd32767)
			return 16'sh7fff;
		else if (v < -35'sd32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

endpackage

@@ rtl/mfp_cordic.sv @@
// Iterative CORDIC: one micro-rotation per cycle, gives Q1.15 cos and sin.
// Depends on mfp_pkg.
module mfp_cordic #(
	parameter int CORDIC_ITERATIONS = mfp_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [15:0] heading,
	output logic done,
	output logic signed [15:0] cos_o,
	output logic signed [15:0] sin_o
);
	localparam int NIT = (CORDIC_ITERATIONS > mfp_pkg::ATAN_ENTRIES) ?
		mfp_pkg::ATAN_ENTRIES : CORDIC_ITERATIONS;

	logic signed [33:0] x_q, y_q, z_q;
	logic [4:0] it_q;
	logic [1:0] quad_q;
	logic busy_q;
	logic [15:0] h, rest;
	logic [1:0] quad;
	logic signed [15:0] c, s;

	always_comb begin
		h = (heading >= mfp_pkg::FULL_TURN) ? heading - mfp_pkg::FULL_TURN : heading;
		if (h >= 16'd34560) begin
			quad = 2'd3; rest = h - 16'd34560;
		end else if (h >= 16'd23040) begin
			quad = 2'd2; rest = h - 16'd23040;
		end else if (h >= mfp_pkg::QUARTER_TURN) begin
			quad = 2'd1; rest = h - mfp_pkg::QUARTER_TURN;
		end else begin
			quad = 2'd0; rest = h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			it_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			it_q <= '0;
		end else if (busy_q) begin
			it_q <= it_q + 5'd1;
			if (it_q == 5'(NIT - 1))
				busy_q <= 1'b0;
		end
	end

	// Arithmetic shift of a signed value is a floor shift.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= mfp_pkg::CORDIC_GAIN;
			y_q <= '0;
			z_q <= 34'($signed({1'b0, rest, 9'd0}));
			quad_q <= quad;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - (y_q >>> it_q);
				y_q <= y_q + (x_q >>> it_q);
				z_q <= z_q - mfp_pkg::atan_lut(it_q);
			end else begin
				x_q <= x_q + (y_q >>> it_q);
				y_q <= y_q - (x_q >>> it_q);
				z_q <= z_q + mfp_pkg::atan_lut(it_q);
			end
		end
	end

	assign done = busy_q && (it_q == 5'(NIT - 1));

	logic signed [34:0] xs, ys;
	always_comb begin
		xs = 35'(x_q >>> 15);
		ys = 35'(y_q >>> 15);
		c = mfp_pkg::sat16(xs);
		s = mfp_pkg::sat16(ys);
	end

	// Quadrant fold is applied after done, when x_q/y_q are final.
	always_comb begin
		case (quad_q)
			2'd0: begin cos_o = c; sin_o = s; end
			2'd1: begin cos_o = mfp_pkg::sat16(-35'(s)); sin_o = c; end
			2'd2: begin
				cos_o = mfp_pkg::sat16(-35'(c)); sin_o = mfp_pkg::sat16(-35'(s));
			end
			default: begin cos_o = s; sin_o = mfp_pkg::sat16(-35'(c)); end
		endcase
	end
endmodule

@@ rtl/mfp_datapath.sv @@
// Datapath: latched start, working state, step counter and position update.
// Depends on mfp_pkg, mfp_cordic and the core defines header.
`include "maneuver_fan_path_predictor_core_defines.svh"
module mfp_datapath #(
	parameter int CORDIC_ITERATIONS = mfp_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  mfp_pkg::in_item_t in_item,
	input  logic [15:0] max_speed,
	input  logic [15:0] max_turn,
	input  mfp_pkg::cmd_t cmd,
	output mfp_pkg::status_t status,
	output mfp_pkg::out_item_t result
);
	logic [63:0] lat_pos_q;
	logic [31:0] lat_sh_q;
	logic [15:0] steps_q, step_counter_q;
	logic [31:0] work_x_q, work_y_q;
	logic [15:0] work_speed_q, work_heading_q;
	logic [3:0] maneuver_index_q;
	logic err_q;
	logic signed [15:0] cos_v, sin_v;
	logic cdone;
	logic [1:0] thr, str;
	logic [16:0] hsum, hdiff;
	logic [15:0] turn, hred;
	logic signed [32:0] px, py;

	always_comb begin
		case (maneuver_index_q)
			4'd0, 4'd1, 4'd2: thr = mfp_pkg::THR_ACCEL;
			4'd3, 4'd4, 4'd5: thr = mfp_pkg::THR_BRAKE;
			default: thr = mfp_pkg::THR_HOLD;
		endcase
		case (maneuver_index_q)
			4'd0, 4'd3, 4'd6: str = mfp_pkg::STR_LEFT;
			4'd1, 4'd4, 4'd7: str = mfp_pkg::STR_RIGHT;
			default: str = mfp_pkg::STR_STRAIGHT;
		endcase
		// Reduce max_turn and the heading mod 360 first; one wrap then suffices.
		turn = (max_turn >= mfp_pkg::FULL_TURN) ? max_turn - mfp_pkg::FULL_TURN : max_turn;
		hred = (work_heading_q >= mfp_pkg::FULL_TURN) ?
			work_heading_q - mfp_pkg::FULL_TURN : work_heading_q;
		hsum = {1'b0, hred} + {1'b0, turn};
		if (hsum >= {1'b0, mfp_pkg::FULL_TURN}) hsum = hsum - {1'b0, mfp_pkg::FULL_TURN};
		hdiff = {1'b0, hred} - {1'b0, turn};
		if (hdiff[16]) hdiff = hdiff + {1'b0, mfp_pkg::FULL_TURN};
		// CORDIC outputs are final in the cycle after done, which is the move cycle.
		px = $signed({1'b0, work_speed_q}) * cos_v;
		py = $signed({1'b0, work_speed_q}) * sin_v;
	end

	mfp_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cmd.cordic_start),
		.heading(work_heading_q), .done(cdone), .cos_o(cos_v), .sin_o(sin_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maneuver_index_q <= '0;
			step_counter_q <= '0;
			err_q <= 1'b0;
		end else begin
			if (cmd.latch) begin
				maneuver_index_q <= '0;
				err_q <= cmd.err;
			end else if (cmd.next)
				maneuver_index_q <= maneuver_index_q + 4'd1;
			if (cmd.load) step_counter_q <= '0;
			else if (cmd.move) step_counter_q <= step_counter_q + 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			lat_pos_q <= {in_item.start_x, in_item.start_y};
			lat_sh_q <= {in_item.start_speed, in_item.start_heading};
			steps_q <= in_item.steps;
		end
		if (cmd.load) begin
			work_x_q <= lat_pos_q[63:32];
			work_y_q <= lat_pos_q[31:0];
			work_speed_q <= lat_sh_q[31:16];
			work_heading_q <= lat_sh_q[15:0];
		end else if (cmd.step) begin
			if (thr == mfp_pkg::THR_ACCEL &&
					({1'b0, work_speed_q} + 17'd128) <= {1'b0, max_speed})
				work_speed_q <= work_speed_q + mfp_pkg::HALF_SPEED;
			else if (thr == mfp_pkg::THR_BRAKE && work_speed_q >= mfp_pkg::HALF_SPEED)
				work_speed_q <= work_speed_q - mfp_pkg::HALF_SPEED;
			// Straight maneuvers keep the stored heading as is.
			if (str == mfp_pkg::STR_LEFT) work_heading_q <= hsum[15:0];
			else if (str == mfp_pkg::STR_RIGHT) work_heading_q <= hdiff[15:0];
		end else if (cmd.move) begin
			work_x_q <= work_x_q + 32'($signed(px >>> 7));
			work_y_q <= work_y_q + 32'($signed(py >>> 7));
		end
	end

	assign status.cordic_done = cdone;
	assign status.steps_done = !steps_q[15] && (step_counter_q >= steps_q);
	assign status.man_last = (maneuver_index_q == 4'd8);

	always_comb begin
		result.end_x = err_q ? '0 : work_x_q;
		result.end_y = err_q ? '0 : work_y_q;
		result.throttle = err_q ? '0 : thr;
		result.steer = err_q ? '0 : str;
		result.error = err_q;
		result.last = err_q || (maneuver_index_q == 4'd8);
	end

	`MFP_ASSERT_NEXT(a_counter_reset, clk, arst_n, cmd.load, step_counter_q == 16'd0,
		"step counter not cleared on load")
	`MFP_ASSERT_IMPL(a_idx_range, clk, arst_n, 1'b1, maneuver_index_q <= 4'd9,
		"maneuver index out of range")
	`MFP_ASSERT_NEXT(a_heading_wrap, clk, arst_n, cmd.step && str != mfp_pkg::STR_STRAIGHT,
		work_heading_q < mfp_pkg::FULL_TURN, "turned heading not below 360")
endmodule

@@ rtl/mfp_ctrl.sv @@
// Controller state machine sequencing maneuvers, steps and result handoff.
// Depends on mfp_pkg and the core defines header.
`include "maneuver_fan_path_predictor_core_defines.svh"
module mfp_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_neg,
	output logic in_stall,
	input  logic out_stall,
	output logic out_valid,
	input  mfp_pkg::status_t status,
	output mfp_pkg::cmd_t cmd
);
	mfp_pkg::state_t state_q, state_d;
	logic err_q, err_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfp_pkg::ST_IDLE;
			err_q <= 1'b0;
		end else begin
			state_q <= state_d;
			err_q <= err_d;
		end
	end

	always_comb begin
		state_d = state_q;
		err_d = err_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			mfp_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch = 1'b1;
					cmd.err = in_neg;
					err_d = in_neg;
					state_d = in_neg ? mfp_pkg::ST_EMIT : mfp_pkg::ST_LOAD;
				end
			end
			mfp_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_d = mfp_pkg::ST_SPEED;
			end
			mfp_pkg::ST_SPEED: begin
				if (status.steps_done) state_d = mfp_pkg::ST_EMIT;
				else begin
					// Update speed and heading before the CORDIC reads the heading.
					cmd.step = 1'b1;
					state_d = mfp_pkg::ST_START;
				end
			end
			mfp_pkg::ST_START: begin
				cmd.cordic_start = 1'b1;
				state_d = mfp_pkg::ST_CORDIC;
			end
			mfp_pkg::ST_CORDIC: begin
				if (status.cordic_done) state_d = mfp_pkg::ST_MOVE;
			end
			mfp_pkg::ST_MOVE: begin
				cmd.move = 1'b1;
				state_d = mfp_pkg::ST_SPEED;
			end
			mfp_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (err_q || status.man_last) state_d = mfp_pkg::ST_IDLE;
					else begin
						cmd.next = 1'b1;
						state_d = mfp_pkg::ST_LOAD;
					end
				end
			end
			default: state_d = mfp_pkg::ST_IDLE;
		endcase
	end

	`MFP_ASSERT_IMPL(a_emit_only, clk, arst_n, out_valid, state_q == mfp_pkg::ST_EMIT,
		"result valid outside emit")
	`MFP_ASSERT_NEXT(a_move_after, clk, arst_n, cmd.move, state_q == mfp_pkg::ST_SPEED,
		"move not followed by speed step")
	`MFP_ASSERT_IMPL(a_no_take, clk, arst_n, state_q != mfp_pkg::ST_IDLE, in_stall,
		"input taken while busy")
endmodule

@@ rtl/maneuver_fan_path_predictor_core.sv @@
// Top level of the maneuver fan path predictor.
// Depends on mfp_pkg, mfp_ctrl, mfp_datapath (with mfp_cordic).
//
// Usage:
//   Input channel in_valid/in_stall/in_data: one start state per transaction.
//   Output channel out_valid/out_stall/out_data: nine results per input in the
//   order al, ar, a-, bl, br, b-, -l, -r, --, the ninth with last set; a
//   negative step count gives a single result with error and last set.
//   Configuration cfg_valid/cfg_ready/cfg_index/cfg_data: index 0 max_speed,
//   index 1 max_turn; other indexes are ignored. Always ready.
// Operation:
//   Each simulated step runs the speed/turn update, the CORDIC start, the
//   iterative CORDIC pass and the position add in turn, bound by the single
//   CORDIC unit. A new input is taken only in the idle cycle after the last
//   result is taken.
// Reset:
//   arst_n clears control and both registers; the block is then idle.
// Stall:
//   A stalled result holds on out_data and the sequence waits for it.
module maneuver_fan_path_predictor_core #(
	parameter int CORDIC_ITERATIONS = mfp_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  mfp_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output mfp_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [15:0] cfg_data
);
	logic [15:0] max_speed_q, max_turn_q;
	mfp_pkg::cmd_t cmd;
	mfp_pkg::status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= '0;
			max_turn_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == {7'd0, mfp_pkg::REG_MAX_SPEED}) max_speed_q <= cfg_data;
			else if (cfg_index == {7'd0, mfp_pkg::REG_MAX_TURN}) max_turn_q <= cfg_data;
		end
	end

	mfp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_neg(in_data.steps[15]),
		.in_stall(in_stall), .out_stall(out_stall), .out_valid(out_valid),
		.status(status), .cmd(cmd)
	);

	mfp_datapath #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .max_speed(max_speed_q),
		.max_turn(max_turn_q), .cmd(cmd), .status(status),
		.result(out_data)
	);
endmodule

@@ dv/tb_maneuver_fan_path_predictor_core.sv @@
// Self-checking testbench of maneuver_fan_path_predictor_core: a bit-exact path predictor
// fed by random and directed start states, with bursty input and a stalling receiver.
// Depends on mfp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_maneuver_fan_path_predictor_core;

	localparam int ITERATIONS = mfp_pkg::CORDIC_ITERATIONS_DEF;
	localparam logic [7:0] IDX_MAX_SPEED = 8'(mfp_pkg::REG_MAX_SPEED);
	localparam logic [7:0] IDX_MAX_TURN = 8'(mfp_pkg::REG_MAX_TURN);
	localparam logic [7:0] IDX_UNUSED = 8'd200;
	localparam int SETTLE_CYCLES = 40;

	localparam logic [1:0] FAN_THR [0:8] = '{mfp_pkg::THR_ACCEL, mfp_pkg::THR_ACCEL,
		mfp_pkg::THR_ACCEL, mfp_pkg::THR_BRAKE, mfp_pkg::THR_BRAKE, mfp_pkg::THR_BRAKE,
		mfp_pkg::THR_HOLD, mfp_pkg::THR_HOLD, mfp_pkg::THR_HOLD};
	localparam logic [1:0] FAN_STR [0:8] = '{mfp_pkg::STR_LEFT, mfp_pkg::STR_RIGHT,
		mfp_pkg::STR_STRAIGHT, mfp_pkg::STR_LEFT, mfp_pkg::STR_RIGHT, mfp_pkg::STR_STRAIGHT,
		mfp_pkg::STR_LEFT, mfp_pkg::STR_RIGHT, mfp_pkg::STR_STRAIGHT};
	localparam longint ANGLE_TAB [0:23] = '{2949120, 1740967, 919879, 466945,
		234379, 117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	mfp_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	mfp_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	logic [15:0] speed_cap = '0;
	logic [15:0] turn_step = '0;
	mfp_pkg::out_item_t endpoints_q[$];
	int mismatches = 0;
	int burst_left = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_cycles = 0;
	int stall_mode = 0;
	int stall_tick = 0;

	maneuver_fan_path_predictor_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic longint clip16(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic void heading_trig(input int unsigned hdg, output longint c_val,
			output longint s_val);
		int unsigned h, quad;
		longint z, x, y, dx, dy, c, s;
		h = hdg % 46080;
		quad = h / 11520;
		z = longint'(h % 11520) * 512;
		x = 652032874;
		y = 0;
		for (int i = 0; i < ITERATIONS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ANGLE_TAB[i];
			end else begin
				x += dx; y -= dy; z += ANGLE_TAB[i];
			end
		end
		c = clip16(x >>> 15);
		s = clip16(y >>> 15);
		case (quad)
			0: begin c_val = c; s_val = s; end
			1: begin c_val = clip16(-s); s_val = c; end
			2: begin c_val = clip16(-c); s_val = clip16(-s); end
			default: begin c_val = s; s_val = clip16(-c); end
		endcase
	endfunction

	function automatic logic [31:0] pos_delta(input logic [15:0] spd, input longint trig);
		longint p;
		p = longint'(spd) * trig;
		return 32'(p >>> 7);
	endfunction

	// Append expected results of one start state: all maneuvers, or one error if steps < 0.
	function automatic void predict_fan(input mfp_pkg::in_item_t it);
		mfp_pkg::out_item_t r;
		logic [31:0] px, py;
		logic [15:0] spd;
		int hdg;
		longint c, s;
		if (it.steps < 0) begin
			r = '0;
			r.error = 1'b1;
			r.last = 1'b1;
			endpoints_q = {endpoints_q, r};
			return;
		end
		for (int m = 0; m < 9; m++) begin
			px = it.start_x;
			py = it.start_y;
			spd = it.start_speed;
			hdg = it.start_heading;
			for (int k = 0; k < int'(it.steps); k++) begin
				if (FAN_THR[m] == mfp_pkg::THR_ACCEL && int'(spd) + 128 <= int'(speed_cap))
					spd = spd + 16'd128;
				else if (FAN_THR[m] == mfp_pkg::THR_BRAKE && spd >= 16'd128)
					spd = spd - 16'd128;
				if (FAN_STR[m] == mfp_pkg::STR_LEFT)
					hdg = (hdg + int'(turn_step)) % 46080;
				else if (FAN_STR[m] == mfp_pkg::STR_RIGHT) begin
					hdg = (hdg - int'(turn_step)) % 46080;
					if (hdg < 0)
						hdg += 46080;
				end
				heading_trig(hdg, c, s);
				px += pos_delta(spd, c);
				py += pos_delta(spd, s);
			end
			r.end_x = px;
			r.end_y = py;
			r.throttle = FAN_THR[m];
			r.steer = FAN_STR[m];
			r.error = 1'b0;
			r.last = (m == 8);
			endpoints_q = {endpoints_q, r};
		end
	endfunction

	// Transaction checker: decide at the falling edge, the transfer happens at the next rise.
	always @(negedge clk) begin
		mfp_pkg::out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (endpoints_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_data);
				mismatches++;
			end else begin
				e = endpoints_q.pop_front();
				if (out_data.end_x !== e.end_x || out_data.end_y !== e.end_y ||
						out_data.throttle !== e.throttle || out_data.steer !== e.steer ||
						out_data.error !== e.error || out_data.last !== e.last) begin
					$display("%0t: mismatch expected %p actual %p", $time, e, out_data);
					mismatches++;
				end
			end
		end
	end

	// Receiver: long hold-off on request, otherwise a randomly chosen stall pattern.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 97 == 0)
			stall_mode <= $urandom_range(0, 3);
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (hold_requests != hold_served) begin
			out_stall <= 1'b1;
			hold_cycles <= 400;
			hold_served <= hold_requests;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				2: out_stall <= stall_tick[1];
				default: out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	task automatic send_item(input mfp_pkg::in_item_t it);
		int gap;
		logic taken;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = $urandom_range(0, 6);
		end else
			gap = 0;
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		predict_fan(it);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (endpoints_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		logic taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		if (idx == IDX_MAX_SPEED)
			speed_cap = val;
		else if (idx == IDX_MAX_TURN)
			turn_step = val;
	endtask

	function automatic mfp_pkg::in_item_t make_item(input logic [31:0] x,
			input logic [31:0] y, input logic [15:0] spd, input logic [15:0] hdg,
			input logic [15:0] n);
		mfp_pkg::in_item_t it;
		it.start_x = x;
		it.start_y = y;
		it.start_speed = spd;
		it.start_heading = hdg;
		it.steps = n;
		return it;
	endfunction

	function automatic mfp_pkg::in_item_t random_item();
		logic [15:0] n;
		logic [15:0] hdg;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			n = 16'h8000 | 16'($urandom);
		else if (pick < 8)
			n = 16'($urandom_range(60, 120));
		else
			n = 16'($urandom_range(0, 10));
		hdg = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 46079));
		return make_item($urandom, $urandom, 16'($urandom), hdg, n);
	endfunction

	task automatic test_reset_values();
		send_item(make_item(32'd0, 32'd0, 16'd300, 16'd0, 16'd3));
		wait_idle();
	endtask

	task automatic test_directed();
		write_reg(IDX_MAX_SPEED, 16'd1000);
		write_reg(IDX_MAX_TURN, 16'd1920);
		write_reg(IDX_UNUSED, 16'hffff);
		send_item(make_item(32'h7fffffff, 32'h80000000, 16'hffff, 16'd0, 16'd2));
		send_item(make_item(32'h80000000, 32'h7fffffff, 16'd0, 16'd46079, 16'd2));
		send_item(make_item(32'h12345678, 32'h9abcdef0, 16'd900, 16'd11520, 16'd0));
		send_item(make_item(32'h0, 32'h0, 16'd100, 16'd23040, 16'hffff));
		send_item(make_item(32'hffffffff, 32'h0, 16'd50, 16'd34560, 16'h8000));
		send_item(make_item(32'h0, 32'hffffffff, 16'd1000, 16'hffff, 16'd3));
		send_item(make_item(32'h10000, 32'h10000, 16'd127, 16'd5760, 16'd1));
		send_item(make_item(32'h0, 32'h0, 16'd872, 16'd46000, 16'd6));
		send_item(make_item(32'h7fff0000, 32'h7fff0000, 16'hff80, 16'd100, 16'd4));
		wait_idle();
		write_reg(IDX_MAX_SPEED, 16'hffff);
		write_reg(IDX_MAX_TURN, 16'hffff);
		send_item(make_item(32'h0, 32'h0, 16'hff00, 16'd46079, 16'd3));
		send_item(make_item(32'hdeadbeef, 32'h01234567, 16'hff7f, 16'hb3ff, 16'd2));
		wait_idle();
		write_reg(IDX_MAX_TURN, 16'd46079);
		send_item(make_item(32'h0, 32'h0, 16'd512, 16'd0, 16'd2));
		wait_idle();
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_item(random_item());
		wait_idle();
	endtask

	task automatic test_config_sweep();
		write_reg(IDX_MAX_SPEED, 16'd0);
		write_reg(IDX_MAX_TURN, 16'd0);
		test_random(15);
		write_reg(IDX_MAX_SPEED, 16'($urandom));
		write_reg(IDX_MAX_TURN, 16'($urandom_range(0, 46079)));
		test_random(35);
		write_reg(IDX_MAX_SPEED, 16'hffff);
		write_reg(IDX_MAX_TURN, 16'd46079);
		test_random(25);
		write_reg(IDX_MAX_SPEED, 16'($urandom));
		write_reg(IDX_MAX_TURN, 16'($urandom));
		test_random(25);
	endtask

	// Hold the receiver off while the sender keeps offering, so the block backs up.
	task automatic test_backpressure();
		hold_requests++;
		for (int i = 0; i < 4; i++)
			send_item(make_item($urandom, $urandom, 16'($urandom), 16'd9000, 16'd1));
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_backpressure();
		test_config_sweep();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#200000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
